[rtl/core/bsoc_pkg.sv]
// ----------------------------------------------------------------------------
// bsoc_pkg
// Shared types and constants of the state-of-charge estimator.
// ----------------------------------------------------------------------------
package bsoc_pkg;

	localparam int MAX_OCV_POINTS_DEF = 32;
	localparam int DVD_W = 48;
	localparam int DVS_W = 26;
	localparam int CNT_W = $clog2(DVD_W);
	localparam int SOC_W = 17;
	localparam logic [SOC_W-1:0] SOC_FULL = 17'd100000;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_RESET = 2'd1,
		OP_LOAD  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_OCV_COUNT = 2'd0,
		REG_FULL_MV   = 2'd1,
		REG_EMPTY_MV  = 2'd2,
		REG_CAP_MAH   = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_TICK_MUL,
		ST_TICK_ACC,
		ST_TICK_CMP,
		ST_TICK_DIV,
		ST_TICK_APPLY,
		ST_EST_RD0,
		ST_EST_RDL,
		ST_EST_CHK,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_EST_MUL,
		ST_EST_DIV,
		ST_EST_APPLY,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

[rtl/core/battery_state_of_charge_estimator_unit.sv]
// ----------------------------------------------------------------------------
// battery_state_of_charge_estimator_unit
// Coulomb-counting state of charge with OCV table or two-point line reset.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one item: op selects a tick
//   (current times elapsed time into the charge accumulator), a reset of the
//   SoC (given percent, or estimate from cell voltage) or a load of one OCV
//   table point. Every item returns exactly one transfer on the output
//   channel (out_valid / out_stall) with the SoC and a changed flag.
//   Items are worked one at a time. A tick uses the serial divide only
//   when the accumulated charge is applied. A voltage estimate over N
//   table points scans the table one entry at a time through the single
//   read port of the table RAM, and may then use the serial divide.
//   The output register frees the input side: a new item is taken in the
//   cycle the pending result transfers. While the receiver stalls, the
//   result holds and no new item is taken.
//   Reset clears SoC and accumulator, sets configuration to defaults; the OCV
//   table holds no defined content until points are loaded.
//   Configuration writes (cfg_we, cfg_index, cfg_data) apply at once.
// ----------------------------------------------------------------------------
module battery_state_of_charge_estimator_unit import bsoc_pkg::*; #(
	parameter int MAX_OCV_POINTS = MAX_OCV_POINTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         op,
	input  logic signed [20:0] current_ma,
	input  logic [15:0]        elapsed_ms,
	input  logic [7:0]         set_percent,
	input  logic [15:0]        cell_voltage_mv,
	input  logic [4:0]         point_index,
	input  logic [15:0]        point_voltage_mv,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [16:0]        soc_millipct,
	output logic               soc_changed,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [19:0]        cfg_data
);

	localparam int AW = $clog2(MAX_OCV_POINTS);
	localparam int NW = $clog2(MAX_OCV_POINTS + 1);

	state_t state_q, state_d;

	// configuration
	logic [5:0]  ocv_count_q;
	logic [15:0] full_mv_q;
	logic [15:0] empty_mv_q;
	logic [19:0] cap_q;

	// architectural state
	logic [SOC_W-1:0]  soc_q;
	logic [DVD_W-1:0]  acc_q;

	// latched item
	logic [1:0]         op_q;
	logic signed [20:0] cur_q;
	logic [15:0]        elap_q;
	logic [7:0]         pct_q;
	logic [15:0]        volt_q;
	logic [SOC_W-1:0]   old_q;

	// working registers
	logic signed [37:0] prod_s1;
	logic [31:0]        thr_q;
	logic [DVS_W-1:0]   dvs_q;
	logic [DVD_W-1:0]   mag_q;
	logic               neg_q;
	logic               fb_q;
	logic               dec_q;
	logic [NW-1:0]      n_q;
	logic [NW-1:0]      i_q;
	logic [16:0]        d_q;
	logic [15:0]        x0_q;
	logic [15:0]        xl_q;
	logic [15:0]        prev_q;
	logic [15:0]        cur_x_q;
	logic [DVD_W-1:0]   num_q;
	logic [15:0]        den_q;
	logic               est_go_q;

	// output register
	logic             out_valid_q;
	logic [SOC_W-1:0] out_soc_q;
	logic             out_chg_q;

	// table RAM
	logic [15:0]   ocv_mem [MAX_OCV_POINTS];
	logic [15:0]   rdata_q;
	logic [AW-1:0] raddr;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic           accept;
	logic [19:0]    cap_eff;
	logic [NW-1:0]  n_eff;
	logic [15:0]    xl_w;
	logic           dec_w;
	logic           clamp_hi;
	logic           clamp_lo;
	logic           hit;
	logic           last;
	logic [DVD_W-1:0] acc_new;
	logic signed [49:0] tick_sum;
	logic signed [39:0] y_i;
	logic signed [39:0] y_im1;
	logic signed [39:0] y_last;
	logic signed [39:0] est_sum;

	bsoc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	function automatic logic signed [39:0] y_at(input logic [16:0] d, input logic [NW-1:0] k);
		logic [23:0] p;
		p = 24'(d * k);
		return 40'sd100000 - $signed({16'd0, p});
	endfunction

	function automatic logic [SOC_W-1:0] clamp40(input logic signed [39:0] s);
		if (s < 0)
			return '0;
		else if (s > $signed({23'd0, SOC_FULL}))
			return SOC_FULL;
		else
			return s[SOC_W-1:0];
	endfunction

	function automatic logic [SOC_W-1:0] clamp50(input logic signed [49:0] s);
		if (s < 0)
			return '0;
		else if (s > $signed({33'd0, SOC_FULL}))
			return SOC_FULL;
		else
			return s[SOC_W-1:0];
	endfunction

	assign cap_eff = (cap_q == '0) ? 20'd1 : cap_q;
	assign n_eff   = (int'(ocv_count_q) > MAX_OCV_POINTS) ? NW'(MAX_OCV_POINTS)
	                                                      : NW'(ocv_count_q);

	// end-point compare; fallback takes its ends from registers
	assign xl_w     = fb_q ? xl_q : rdata_q;
	assign dec_w    = x0_q >= xl_w;
	assign clamp_hi = dec_w ? (volt_q >= x0_q) : (volt_q <= x0_q);
	assign clamp_lo = dec_w ? (volt_q <= xl_w) : (volt_q >= xl_w);
	assign hit      = dec_q ? (volt_q >= rdata_q) : (volt_q <= rdata_q);
	assign last     = (i_q + 1'b1) == n_q;

	assign acc_new  = acc_q + DVD_W'(prod_s1);
	assign tick_sum = $signed({33'd0, soc_q})
	                + (neg_q ? -$signed({2'b0, div_rsp.quotient})
	                         : $signed({2'b0, div_rsp.quotient}));

	assign y_i    = y_at(d_q, i_q);
	assign y_im1  = y_at(d_q, i_q - 1'b1);
	assign y_last = y_at(d_q, n_q - 1'b1);
	assign est_sum = dec_q ? (y_i + $signed({1'b0, div_rsp.quotient[38:0]}))
	                       : (y_im1 - $signed({1'b0, div_rsp.quotient[38:0]}));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (accept) state_d = ST_DISPATCH;
			ST_DISPATCH: begin
				case (op_q)
					OP_TICK:  state_d = ST_TICK_MUL;
					OP_RESET: begin
						if (pct_q <= 8'd100)
							state_d = ST_DONE;
						else if (ocv_count_q == '0)
							state_d = ST_EST_CHK;
						else if (n_eff <= NW'(1))
							state_d = ST_DONE;
						else
							state_d = ST_EST_RD0;
					end
					default:  state_d = ST_DONE;
				endcase
			end
			ST_TICK_MUL: state_d = ST_TICK_ACC;
			ST_TICK_ACC: state_d = ST_TICK_CMP;
			ST_TICK_CMP: state_d = (mag_q > DVD_W'(thr_q)) ? ST_TICK_DIV : ST_DONE;
			ST_TICK_DIV: if (div_rsp.done) state_d = ST_TICK_APPLY;
			ST_TICK_APPLY: state_d = ST_DONE;
			ST_EST_RD0:  state_d = ST_EST_RDL;
			ST_EST_RDL:  state_d = ST_EST_CHK;
			ST_EST_CHK: begin
				if (clamp_hi || clamp_lo)
					state_d = ST_DONE;
				else if (fb_q)
					state_d = ST_EST_MUL;
				else
					state_d = ST_SCAN_RD;
			end
			ST_SCAN_RD:  state_d = ST_SCAN_CMP;
			ST_SCAN_CMP: begin
				if (hit)
					state_d = ST_EST_MUL;
				else if (last)
					state_d = ST_DONE;
				else
					state_d = ST_SCAN_RD;
			end
			ST_EST_MUL:  state_d = ST_EST_DIV;
			ST_EST_DIV:  if (div_rsp.done) state_d = ST_EST_APPLY;
			ST_EST_APPLY: state_d = ST_DONE;
			ST_DONE:     state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_stall = !((state_q == ST_IDLE) && (!out_valid_q || !out_stall));
		raddr    = '0;
		div_req.start    = 1'b0;
		div_req.dividend = num_q;
		div_req.divisor  = DVS_W'(den_q);
		case (state_q)
			ST_EST_RDL: raddr = AW'(n_q - 1'b1);
			ST_SCAN_RD: raddr = i_q[AW-1:0];
			ST_TICK_CMP: begin
				div_req.start    = mag_q > DVD_W'(thr_q);
				div_req.dividend = mag_q;
				div_req.divisor  = dvs_q;
			end
			ST_EST_MUL: div_req.start = 1'b0;
			// estimate divide starts once operands are registered
			ST_EST_DIV: div_req.start = est_go_q;
			default: ;
		endcase
	end

	assign accept = in_valid && !in_stall;

	// launch estimate divide on entry to the wait state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			est_go_q <= 1'b0;
		else
			est_go_q <= (state_q == ST_EST_MUL);
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			ocv_count_q <= '0;
			full_mv_q   <= 16'd4200;
			empty_mv_q  <= 16'd3000;
			cap_q       <= 20'd10000;
			soc_q       <= '0;
			acc_q       <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_OCV_COUNT: ocv_count_q <= cfg_data[5:0];
					REG_FULL_MV:   full_mv_q   <= cfg_data[15:0];
					REG_EMPTY_MV:  empty_mv_q  <= cfg_data[15:0];
					REG_CAP_MAH:   cap_q       <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_DONE)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_DISPATCH: begin
					if (op_q == OP_RESET) begin
						if (pct_q <= 8'd100)
							soc_q <= SOC_W'(pct_q * 10'd1000);
						else if (ocv_count_q != '0 && n_eff <= NW'(1))
							soc_q <= SOC_FULL;
					end
				end
				ST_TICK_ACC:   acc_q <= acc_new;
				ST_TICK_APPLY: begin
					soc_q <= clamp50(tick_sum);
					acc_q <= '0;
				end
				ST_EST_CHK: begin
					if (clamp_hi)
						soc_q <= SOC_FULL;
					else if (clamp_lo)
						soc_q <= clamp40(y_last);
				end
				ST_SCAN_CMP: if (!hit && last) soc_q <= clamp40(y_last);
				ST_EST_APPLY: soc_q <= clamp40(est_sum);
				default: ;
			endcase
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op;
			cur_q  <= current_ma;
			elap_q <= elapsed_ms;
			pct_q  <= set_percent;
			volt_q <= cell_voltage_mv;
			old_q  <= soc_q;
		end
		case (state_q)
			ST_DISPATCH: begin
				fb_q <= (ocv_count_q == '0);
				if (ocv_count_q == '0) begin
					x0_q <= full_mv_q;
					xl_q <= empty_mv_q;
					n_q  <= NW'(2);
					d_q  <= 17'd100000;
				end else begin
					n_q  <= n_eff;
					d_q  <= 17'd5000;
				end
			end
			ST_TICK_MUL: begin
				prod_s1 <= 38'(cur_q * $signed({1'b0, elap_q}));
				thr_q   <= 32'(cap_eff * 12'd3600);
				dvs_q   <= DVS_W'(cap_eff * 6'd36);
			end
			ST_TICK_ACC: begin
				neg_q <= acc_new[DVD_W-1];
				mag_q <= acc_new[DVD_W-1] ? DVD_W'(-acc_new) : acc_new;
			end
			ST_EST_RDL: x0_q <= rdata_q;
			ST_EST_CHK: begin
				dec_q   <= dec_w;
				prev_q  <= x0_q;
				cur_x_q <= xl_w;
				i_q     <= NW'(1);
			end
			ST_SCAN_CMP: begin
				if (hit) begin
					cur_x_q <= rdata_q;
				end else begin
					prev_q <= rdata_q;
					i_q    <= i_q + 1'b1;
				end
			end
			ST_EST_MUL: begin
				num_q <= DVD_W'(d_q * (dec_q ? (volt_q - cur_x_q) : (volt_q - prev_q)));
				den_q <= dec_q ? (prev_q - cur_x_q) : (cur_x_q - prev_q);
			end
			ST_DONE: begin
				out_soc_q <= soc_q;
				out_chg_q <= soc_q != old_q;
			end
			default: ;
		endcase
	end

	// table RAM: write on load transfer, registered read
	always_ff @(posedge clk) begin
		if (accept && op == OP_LOAD && int'(point_index) < MAX_OCV_POINTS)
			ocv_mem[AW'(point_index)] <= point_voltage_mv;
		rdata_q <= ocv_mem[raddr];
	end

	assign out_valid    = out_valid_q;
	assign soc_millipct = out_soc_q;
	assign soc_changed  = out_chg_q;

endmodule

[rtl/core/bsoc_div.sv]
// ----------------------------------------------------------------------------
// bsoc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bsoc_div import bsoc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvs_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			// shift in next dividend bit, subtract where it fits
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule
